// File: sv/efsd_pkg.sv
`timescale 1ns / 1ps
package efsd_pkg;

	localparam int MAX_SERVERS = 16;
	localparam int IDX_W       = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int CNT_W       = $clog2(MAX_SERVERS + 1);

	localparam int TIME_W   = 32;
	localparam int ARR_W    = 20;
	localparam int SVC_W    = 16;
	localparam int WAIT_W   = 16;
	localparam int NSRV_W   = 5;
	localparam int SIDX_W   = 4;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 72;
	localparam int ADDR_W   = 3;
	localparam int APB_W    = 32;

	localparam logic [NSRV_W-1:0] NSRV_RESET = 5'd1;
	localparam logic [WAIT_W-1:0] WAIT_RESET = 16'd20;
	localparam logic [TIME_W-1:0] TIME_SAT   = {TIME_W{1'b1}};

	typedef enum logic [0:0] {
		REG_NUM_SERVERS = 1'b0,
		REG_WAIT_LIMIT  = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_JUDGE,
		ST_COMMIT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [NSRV_W-1:0] num_servers;
		logic [WAIT_W-1:0] wait_limit;
	} cfg_t;

	typedef struct packed {
		logic              clr;
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [TIME_W-1:0] wdata;
	} file_ctrl_t;

	typedef struct packed {
		logic [SIDX_W-1:0] server_index;
		logic              was_late;
		logic [TIME_W-1:0] late_count;
		logic [TIME_W-1:0] start_time;
	} result_t;

	// Zero servers counts as one; anything above the built maximum is clipped.
	function automatic logic [CNT_W-1:0] servers_in_use(input logic [NSRV_W-1:0] ns);
		logic [CNT_W-1:0] n;
		if (ns == '0) begin
			n = CNT_W'(1);
		end else if (int'(ns) > MAX_SERVERS) begin
			n = CNT_W'(MAX_SERVERS);
		end else begin
			n = CNT_W'(ns);
		end
		return n;
	endfunction

endpackage

// File: sv/efsd_cfg.sv
`timescale 1ns / 1ps
module efsd_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [efsd_pkg::ADDR_W-1:0]  paddr,
	input  logic [efsd_pkg::APB_W-1:0]   pwdata,
	output logic [efsd_pkg::APB_W-1:0]   prdata,
	output logic                         pready,
	output efsd_pkg::cfg_t               cfg
);
	import efsd_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t sel;
	logic     wr_en;

	assign pready = 1'b1;
	assign sel    = reg_idx_t'(paddr[2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_servers <= NSRV_RESET;
			cfg_q.wait_limit  <= WAIT_RESET;
		end else if (wr_en) begin
			case (sel)
				REG_NUM_SERVERS: cfg_q.num_servers <= pwdata[NSRV_W-1:0];
				REG_WAIT_LIMIT:  cfg_q.wait_limit  <= pwdata[WAIT_W-1:0];
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (sel)
			REG_NUM_SERVERS: prdata = APB_W'(cfg_q.num_servers);
			REG_WAIT_LIMIT:  prdata = APB_W'(cfg_q.wait_limit);
			default:         prdata = '0;
		endcase
	end

endmodule

// File: sv/efsd_free_file.sv
`timescale 1ns / 1ps
module efsd_free_file (
	input  logic                         clk,
	input  logic                         arst_n,
	input  efsd_pkg::file_ctrl_t         ctrl,
	input  logic [efsd_pkg::IDX_W-1:0]   raddr,
	output logic [efsd_pkg::TIME_W-1:0]  rdata
);
	import efsd_pkg::*;

	logic [TIME_W-1:0] free_q [MAX_SERVERS];

	// Clear all entries at once on a new batch; otherwise write the chosen server.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SERVERS; i++) free_q[i] <= '0;
		end else if (ctrl.clr) begin
			for (int i = 0; i < MAX_SERVERS; i++) free_q[i] <= '0;
		end else if (ctrl.we) begin
			free_q[ctrl.waddr] <= ctrl.wdata;
		end
	end

	assign rdata = free_q[raddr];

endmodule

// File: sv/efsd_core.sv
`timescale 1ns / 1ps
module efsd_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  efsd_pkg::cfg_t               cfg,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         in_new_batch,
	input  logic [efsd_pkg::ARR_W-1:0]   in_arrival,
	input  logic [efsd_pkg::SVC_W-1:0]   in_service,
	output logic                         res_valid,
	input  logic                         res_ready,
	output efsd_pkg::result_t            res,
	output efsd_pkg::file_ctrl_t         file_ctrl,
	output logic [efsd_pkg::IDX_W-1:0]   file_raddr,
	input  logic [efsd_pkg::TIME_W-1:0]  file_rdata
);
	import efsd_pkg::*;

	state_t            state_q, state_d;
	logic [ARR_W-1:0]  arrival_q;
	logic [SVC_W-1:0]  service_q;
	logic [WAIT_W-1:0] wait_q;
	logic [CNT_W-1:0]  n_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  best_q;
	logic [TIME_W-1:0] best_val_q;
	logic              late_q;
	logic [TIME_W-1:0] start_q;
	logic [TIME_W-1:0] late_total_q;
	logic              accept;
	logic              last_idx;
	logic              take;
	logic [TIME_W-1:0] arrival_w;
	logic [TIME_W-1:0] limit;
	logic [TIME_W:0]   sum;
	logic [TIME_W-1:0] new_free;

	assign accept    = in_valid & in_ready;
	assign last_idx  = (idx_q == IDX_W'(n_q - CNT_W'(1)));
	// Shared comparator: first entry always taken, strict less keeps lowest index.
	assign take      = (idx_q == '0) || (file_rdata < best_val_q);
	assign arrival_w = TIME_W'(arrival_q);
	assign limit     = arrival_w + TIME_W'(wait_q);
	assign sum       = {1'b0, start_q} + (TIME_W + 1)'(service_q);
	assign new_free  = sum[TIME_W] ? TIME_SAT : sum[TIME_W-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (accept) state_d = ST_SCAN;
			ST_SCAN:   if (last_idx) state_d = ST_JUDGE;
			ST_JUDGE:  state_d = ST_COMMIT;
			ST_COMMIT: state_d = ST_OUT;
			ST_OUT:    if (res_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = 1'b0;
		res_valid       = 1'b0;
		file_ctrl.clr   = 1'b0;
		file_ctrl.we    = 1'b0;
		file_ctrl.waddr = best_q;
		file_ctrl.wdata = new_free;
		case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				file_ctrl.clr = in_valid & in_new_batch;
			end
			ST_COMMIT: file_ctrl.we = 1'b1;
			ST_OUT:    res_valid = 1'b1;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign file_raddr = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			late_total_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept && in_new_batch) begin
				late_total_q <= '0;
			end else if (state_q == ST_COMMIT && late_q && late_total_q != TIME_SAT) begin
				late_total_q <= late_total_q + TIME_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				arrival_q <= in_arrival;
				service_q <= in_service;
				wait_q    <= cfg.wait_limit;
				n_q       <= servers_in_use(cfg.num_servers);
				idx_q     <= '0;
			end
			ST_SCAN: begin
				if (take) begin
					best_q     <= idx_q;
					best_val_q <= file_rdata;
				end
				idx_q <= idx_q + IDX_W'(1);
			end
			ST_JUDGE: begin
				late_q  <= best_val_q > limit;
				start_q <= (best_val_q < arrival_w) ? arrival_w : best_val_q;
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	assign res.server_index = SIDX_W'(best_q);
	assign res.was_late     = late_q;
	assign res.late_count   = late_total_q;
	assign res.start_time   = start_q;

endmodule

// File: sv/earliest_free_server_dispatch_unit.sv
`timescale 1ns / 1ps
// Earliest-free-server dispatch.
// Jobs enter on the s_* stream (one job per transaction) and leave on the m_*
// stream, one result per job, in order. Each job goes to the server, among the
// configured ones, with the smallest free-at time; ties go to the lowest index.
// The APB port sets num_servers (address 0) and wait_limit (address 4); write
// only while no job is in flight.
// Timing: a job scans one server free time per cycle through a single shared
// comparator, then judges lateness (ST_JUDGE) and commits the new free time
// (ST_COMMIT); the result is then offered from ST_OUT, and the next job is
// accepted once the sequencer has handed it on and returned to idle.
// s_tready is high only while the sequencer idles.
// Stall: the result sits in an output register; a new job may be accepted
// while it waits, but the sequencer holds its finished result until the
// register drains.
// Reset: all server free times, the late count and the output valid clear;
// num_servers returns to 1 and wait_limit to 20. A set new_batch flag clears
// the free times and the late count before its own job is handled.
module earliest_free_server_dispatch_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// job stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [efsd_pkg::S_DATA_W-1:0] s_tdata,  // arrival_time[19:0], service_time[35:20]
	input  logic                          s_tuser,  // new_batch
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [efsd_pkg::M_DATA_W-1:0] m_tdata,  // server_index, was_late, late_count,
	                                                // start_time
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [efsd_pkg::ADDR_W-1:0]   paddr,
	input  logic [efsd_pkg::APB_W-1:0]    pwdata,
	output logic [efsd_pkg::APB_W-1:0]    prdata,
	output logic                          pready
);
	import efsd_pkg::*;

	cfg_t              cfg;
	file_ctrl_t        file_ctrl;
	logic [IDX_W-1:0]  file_raddr;
	logic [TIME_W-1:0] file_rdata;
	logic              res_valid;
	logic              res_ready;
	result_t           res;
	logic              m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;

	efsd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	efsd_free_file u_file (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (file_ctrl),
		.raddr  (file_raddr),
		.rdata  (file_rdata)
	);

	efsd_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_new_batch (s_tuser),
		.in_arrival   (s_tdata[ARR_W-1:0]),
		.in_service   (s_tdata[ARR_W+SVC_W-1:ARR_W]),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res),
		.file_ctrl    (file_ctrl),
		.file_raddr   (file_raddr),
		.file_rdata   (file_rdata)
	);

	// Load the output register whenever it is empty or being drained.
	assign res_ready = ~m_tvalid_q | m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	// Pack fields lowest first; pad to whole bytes.
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_tdata_q <= M_DATA_W'({res.start_time, res.late_count,
				res.was_late, res.server_index});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// File: sv/efsd_checker.sv
`timescale 1ns / 1ps
module efsd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [efsd_pkg::M_DATA_W-1:0] m_tdata
);
	import efsd_pkg::*;

	// Hold a stalled result steady.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed or dropped");

	// Stay busy after taking a job.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##1 !s_tready ##1 !s_tready)
		else $error("job accepted while the sequencer was busy");

	// A fresh result is only possible once the sequencer has left idle.
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !s_tready || $past(!s_tready))
		else $error("result appeared without a job in flight");

endmodule

bind earliest_free_server_dispatch_unit efsd_checker u_efsd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
